>>> design/rlelg_pkg.sv
`timescale 1ns / 1ps

package rlelg_pkg;

	localparam int unsigned JobBytes = 5;
	localparam int unsigned JobCountW = 3;

	localparam logic [7:0] MARK_BYTE    = 8'h31;
	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
	localparam logic [7:0] DIGIT_ZERO   = 8'h30;

	// Bytes that one input item causes, in output order, slot 0 first.
	typedef struct packed {
		logic [JobCountW-1:0]         count;
		logic [JobBytes-1:0][7:0]     bytes;
	} job_t;

endpackage

>>> design/rlelg_front.sv
`timescale 1ns / 1ps

module rlelg_front #(
	parameter int unsigned MAX_RUN = 9
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         char_in,
	input  logic               line_end,
	output rlelg_pkg::job_t    job
);

	localparam logic [3:0] MaxRunLen = 4'(MAX_RUN);

	logic [7:0] run_byte_q;
	logic [3:0] run_length_q;
	logic       literal_open_q;

	logic [7:0] run_byte_d;
	logic [3:0] run_length_d;
	logic       literal_open_d;

	always_comb begin
		logic [rlelg_pkg::JobCountW-1:0] n;
		logic                            same;
		logic                            do_flush;
		job            = '0;
		n              = '0;
		run_byte_d     = run_byte_q;
		run_length_d   = run_length_q;
		literal_open_d = literal_open_q;
		same     = (run_length_q != 4'd0) && (char_in == run_byte_q);
		do_flush = line_end || !same;

		if (do_flush) begin
			if (run_length_q == 4'd1) begin
				if (!literal_open_d) begin
					job.bytes[n] = rlelg_pkg::MARK_BYTE;
					n = n + 3'd1;
					literal_open_d = 1'b1;
				end
				job.bytes[n] = run_byte_q;
				n = n + 3'd1;
				// A literal marker byte is escaped by doubling it.
				if (run_byte_q == rlelg_pkg::MARK_BYTE) begin
					job.bytes[n] = rlelg_pkg::MARK_BYTE;
					n = n + 3'd1;
				end
			end else if (run_length_q >= 4'd2) begin
				if (literal_open_d) begin
					job.bytes[n] = rlelg_pkg::MARK_BYTE;
					n = n + 3'd1;
					literal_open_d = 1'b0;
				end
				job.bytes[n] = rlelg_pkg::DIGIT_ZERO + {4'd0, run_length_q};
				n = n + 3'd1;
				job.bytes[n] = run_byte_q;
				n = n + 3'd1;
			end
			run_length_d = 4'd0;
		end else if (run_length_q >= MaxRunLen) begin
			// A full chunk goes out and the new byte starts the next run.
			if (literal_open_d) begin
				job.bytes[n] = rlelg_pkg::MARK_BYTE;
				n = n + 3'd1;
				literal_open_d = 1'b0;
			end
			job.bytes[n] = rlelg_pkg::DIGIT_ZERO + {4'd0, MaxRunLen};
			n = n + 3'd1;
			job.bytes[n] = run_byte_q;
			n = n + 3'd1;
			run_length_d = 4'd1;
		end else begin
			run_length_d = run_length_q + 4'd1;
		end

		if (line_end) begin
			if (literal_open_d) begin
				job.bytes[n] = rlelg_pkg::MARK_BYTE;
				n = n + 3'd1;
				literal_open_d = 1'b0;
			end
			job.bytes[n] = rlelg_pkg::NEWLINE_BYTE;
			n = n + 3'd1;
		end else if (do_flush) begin
			run_byte_d   = char_in;
			run_length_d = 4'd1;
		end
		job.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_byte_q     <= '0;
			run_length_q   <= '0;
			literal_open_q <= 1'b0;
		end else if (accept) begin
			run_byte_q     <= run_byte_d;
			run_length_q   <= run_length_d;
			literal_open_q <= literal_open_d;
		end
	end

endmodule

>>> design/rlelg_queue.sv
`timescale 1ns / 1ps

module rlelg_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rlelg_pkg::job_t    push_job,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output rlelg_pkg::job_t    head_job
);

	rlelg_pkg::job_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      fill_q;

	assign full       = (fill_q == 2'd2);
	assign head_valid = (fill_q != 2'd0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

>>> design/rlelg_back.sv
`timescale 1ns / 1ps

module rlelg_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  rlelg_pkg::job_t    head_job,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         byte_out,
	output logic               last_out
);

	logic [rlelg_pkg::JobCountW-1:0] idx_q;
	logic                            out_valid_q;
	logic [7:0]                      byte_q;
	logic                            last_q;
	logic                            load;
	logic                            is_last;

	assign load    = head_valid && (!out_valid_q || out_ready);
	assign is_last = (idx_q == head_job.count - 3'd1);
	assign pop     = load && is_last;

	assign out_valid = out_valid_q;
	assign byte_out  = byte_q;
	assign last_out  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? '0 : idx_q + 3'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head_job.bytes[idx_q];
			last_q <= is_last;
		end
	end

endmodule

>>> design/run_length_encoder_literal_groups_core.sv
`timescale 1ns / 1ps

// Streaming run-length encoder with escaped literal groups.
// Input channel (in_valid/in_ready): one item per byte of a line in char_in,
// or a line end when line_end is high (char_in is then ignored).
// Output channel (out_valid/out_ready): one encoded byte per item in
// byte_out; last_out marks the final byte caused by one input item. Items
// that only extend a run produce nothing.
// The front stage updates the run state and builds the list of up to five
// output bytes for each item in the cycle it is accepted; a two-entry queue
// holds those lists and the back stage sends one byte per cycle while the
// receiver takes it. The first byte of an item passes through a queue entry
// and then the output register before it is valid. Throughput: the output
// port moves one byte per cycle while out_ready is high; an item yields one
// to five bytes, and items that yield nothing are accepted while the queue
// is not full. When the receiver stalls, the output register holds its
// byte, the queue fills, and in_ready drops once both entries are occupied.
// Reset clears the run state, the queue and the output valid flag.
module run_length_encoder_literal_groups_core #(
	parameter int unsigned MAX_RUN = 9
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	input  logic       line_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] byte_out,
	output logic       last_out
);

	rlelg_pkg::job_t job;
	rlelg_pkg::job_t head_job;
	logic            accept;
	logic            full;
	logic            head_valid;
	logic            pop;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	rlelg_front #(
		.MAX_RUN(MAX_RUN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.char_in  (char_in),
		.line_end (line_end),
		.job      (job)
	);

	rlelg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept && (job.count != '0)),
		.push_job   (job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	rlelg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.byte_out   (byte_out),
		.last_out   (last_out)
	);

endmodule
